// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric compensation core: register
// indexes, oversampling scale factors and the multiplier stage enables.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // default number of fraction bits of the scaled readings
  localparam int unsigned SCALE_FRAC_BITS = 24;

  // width of the polynomial accumulators (signed)
  localparam int unsigned ACC_W = 64;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_16_17 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OSR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_OSR   = 3'd4;

  // scale factor for each oversampling code
  localparam logic [63:0] OSR_SCALE [8] = '{
    64'd524288,  64'd1572864, 64'd3670016, 64'd7864320,
    64'd253952,  64'd516096,  64'd1040384, 64'd2088960
  };

  // load enables of the four stages of one rounding multiplier
  typedef struct packed {
    logic pp;    // partial products
    logic part;  // partial sums
    logic sum;   // full product
    logic rnd;   // rounded result
  } mul_en_t;

endpackage

// ===== hdl/bpc_mul_round.sv =====
// ----------------------------------------------------------------------------
// bpc_mul_round
// Four-stage signed multiplier that returns round(a * b / 2^SH) with ties
// away from zero, split into partial products of at most 33 x 18 bits.
// ----------------------------------------------------------------------------
module bpc_mul_round #(
  parameter int unsigned BW = 34,
  parameter int unsigned SH = 24
) (
  input  logic                                  clk_i,
  input  bpc_pkg::mul_en_t                      en_i,
  input  logic signed [bpc_pkg::ACC_W-1:0]      a_i,
  input  logic signed [BW-1:0]                  b_i,
  output logic signed [bpc_pkg::ACC_W-1:0]      q_o
);

  localparam int unsigned AW    = bpc_pkg::ACC_W;
  localparam int unsigned AL    = AW / 2;
  localparam int unsigned BL    = BW / 2;
  localparam int unsigned BH    = BW - BL;
  localparam int unsigned PPW   = AL + BH + 2;
  localparam int unsigned SW    = PPW + BL + 1;
  localparam int unsigned PRODW = AW + BW;

  localparam logic signed [PRODW-1:0] HALF = PRODW'(1) << (SH - 1);

  logic [AL-1:0]           al;
  logic signed [AW-AL-1:0] ah;
  logic [BL-1:0]           bl;
  logic signed [BH-1:0]    bh;

  logic signed [PPW-1:0]   pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic signed [SW-1:0]    s_lo_q, s_hi_q;
  logic signed [PRODW-1:0] prod_q;
  logic signed [PRODW-1:0] corr, adj, shifted;

  assign al = a_i[AL-1:0];
  assign ah = $signed(a_i[AW-1:AL]);
  assign bl = b_i[BL-1:0];
  assign bh = $signed(b_i[BW-1:BL]);

  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      pp_ll_q <= $signed({1'b0, al}) * $signed({1'b0, bl});
      pp_lh_q <= $signed({1'b0, al}) * bh;
      pp_hl_q <= ah * $signed({1'b0, bl});
      pp_hh_q <= ah * bh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      s_lo_q <= SW'(pp_ll_q) + (SW'(pp_lh_q) <<< BL);
      s_hi_q <= SW'(pp_hl_q) + (SW'(pp_hh_q) <<< BL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      prod_q <= PRODW'(s_lo_q) + (PRODW'(s_hi_q) <<< AL);
    end
  end

  // a negative product rounds with half minus one, so ties go away from zero
  always_comb begin
    corr    = PRODW'(prod_q[PRODW-1]);
    adj     = prod_q + HALF - corr;
    shifted = adj >>> SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.rnd) begin
      q_o <= shifted[AW-1:0];
    end
  end

endmodule

// ===== hdl/barometric_pressure_compensation_core.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Compensates raw barometer temperature and pressure readings with the
// calibration polynomial, rounding and saturating the results.
//
//   channel  | dir | handshake                      | content
//   ---------+-----+--------------------------------+-------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready  | raw temperature, pressure
//   m_axis   | out | m_axis_tvalid / m_axis_tready  | temperature, pressure
//   cfg      | in  | cfg_valid_i / cfg_ready_o      | register index, data
//
// One request per cycle enters and leaves while the output is taken; it passes
// two chained rounding multipliers of the pressure polynomial (4 stages each).
// Each stage has its own valid bit; a stage loads while it or any later stage
// is empty or the output is taken, so bubbles close up under a stall.
// Reset clears the valid bits and all configuration registers.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_core #(
  parameter int unsigned SCALE_FRAC_BITS = bpc_pkg::SCALE_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [47:0]                      s_axis_tdata,  // temp_reading, pres_reading
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [71:0]                      m_axis_tdata,  // temp_out, pres_out
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [63:0]                      cfg_data_i
);

  localparam int unsigned F    = SCALE_FRAC_BITS;
  localparam int unsigned RW   = F - 15;
  localparam int unsigned PW   = F + 10;
  localparam int unsigned MW   = PW + 16;
  localparam int unsigned CTW  = PW + 12;
  localparam int unsigned TW   = PW + 13;
  localparam int unsigned TRW  = TW - F + 9;
  localparam int unsigned PRW  = 71 - F;
  localparam int unsigned ACC  = bpc_pkg::ACC_W;
  localparam int unsigned ACC1 = ACC + 1;

  // stage indexes
  localparam int unsigned ST_SCALE = 0;
  localparam int unsigned ST_MULC  = 1;
  localparam int unsigned ST_ADD1  = 2;
  localparam int unsigned ST_M1    = 3;
  localparam int unsigned ST_ADD2  = 7;
  localparam int unsigned ST_M2    = 8;
  localparam int unsigned ST_ADD3  = 12;
  localparam int unsigned ST_SUM   = 13;
  localparam int unsigned ST_RND   = 14;
  localparam int unsigned ST_OUT   = 15;
  localparam int unsigned NST      = 16;

  localparam logic [RW-1:0] RECIP [8] = '{
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[0] / 2) / bpc_pkg::OSR_SCALE[0]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[1] / 2) / bpc_pkg::OSR_SCALE[1]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[2] / 2) / bpc_pkg::OSR_SCALE[2]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[3] / 2) / bpc_pkg::OSR_SCALE[3]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[4] / 2) / bpc_pkg::OSR_SCALE[4]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[5] / 2) / bpc_pkg::OSR_SCALE[5]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[6] / 2) / bpc_pkg::OSR_SCALE[6]),
    RW'(((64'd1 << F) + bpc_pkg::OSR_SCALE[7] / 2) / bpc_pkg::OSR_SCALE[7])
  };

  localparam logic signed [TW-1:0]   T_HALF = TW'(1) << (F - 9);
  localparam logic signed [ACC1-1:0] P_HALF = ACC1'(1) << (F - 7);
  localparam logic signed [63:0]     T_MAX  = 64'sd2147483647;
  localparam logic signed [63:0]     T_MIN  = -64'sd2147483648;
  localparam logic signed [63:0]     P_MAX  = 64'sd549755813887;
  localparam logic signed [63:0]     P_MIN  = -64'sd549755813888;

  // configuration registers
  logic [63:0] coef_0_7_q, coef_8_15_q;
  logic [15:0] coef_16_17_q;
  logic [2:0]  temp_osr_q, pres_osr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_0_7_q   <= '0;
      coef_8_15_q  <= '0;
      coef_16_17_q <= '0;
      temp_osr_q   <= '0;
      pres_osr_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpc_pkg::REG_COEF_0_7:   coef_0_7_q   <= cfg_data_i;
        bpc_pkg::REG_COEF_8_15:  coef_8_15_q  <= cfg_data_i;
        bpc_pkg::REG_COEF_16_17: coef_16_17_q <= cfg_data_i[15:0];
        bpc_pkg::REG_TEMP_OSR:   temp_osr_q   <= cfg_data_i[2:0];
        bpc_pkg::REG_PRES_OSR:   pres_osr_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // calibration coefficients, byte 0 in the top of the first word
  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0  = $signed(coef_0_7_q[63:52]);
  assign c1  = $signed(coef_0_7_q[51:40]);
  assign c00 = $signed(coef_0_7_q[39:20]);
  assign c10 = $signed(coef_0_7_q[19:0]);
  assign c01 = $signed(coef_8_15_q[63:48]);
  assign c11 = $signed(coef_8_15_q[47:32]);
  assign c20 = $signed(coef_8_15_q[31:16]);
  assign c21 = $signed(coef_8_15_q[15:0]);
  assign c30 = $signed(coef_16_17_q);

  // stage valid bits and load enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  // a stage may load when some stage at or after it is empty, or when the output is taken
  always_comb begin
    logic [NST-1:0] low;
    for (int k = 0; k < NST; k++) begin
      low    = (NST'(1) << k) - NST'(1);
      adv[k] = m_axis_tready || ((v_q | low) != '1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = v_q[ST_OUT];

  // scaled readings, carried up to the second multiplier pass
  logic signed [PW-1:0] tsc_q [ST_SCALE:ST_ADD2];
  logic signed [PW-1:0] psc_q [ST_SCALE:ST_ADD2];
  logic signed [23:0]   temp_raw, pres_raw;

  assign temp_raw = $signed(s_axis_tdata[23:0]);
  assign pres_raw = $signed(s_axis_tdata[47:24]);

  always_ff @(posedge clk_i) begin
    if (adv[ST_SCALE]) begin
      tsc_q[ST_SCALE] <= $signed({1'b0, RECIP[temp_osr_q]}) * temp_raw;
      psc_q[ST_SCALE] <= $signed({1'b0, RECIP[pres_osr_q]}) * pres_raw;
    end
    for (int k = ST_SCALE + 1; k <= ST_ADD2; k++) begin
      if (adv[k]) begin
        tsc_q[k] <= tsc_q[k-1];
        psc_q[k] <= psc_q[k-1];
      end
    end
  end

  // coefficient products
  logic signed [CTW-1:0] ct_q;
  logic signed [MW-1:0]  m30_q, m21_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_MULC]) begin
      ct_q  <= c1 * tsc_q[ST_SCALE];
      m30_q <= c30 * psc_q[ST_SCALE];
      m21_q <= c21 * psc_q[ST_SCALE];
    end
  end

  logic signed [TW-1:0]  t2_q;
  logic signed [ACC-1:0] a1_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_ADD1]) begin
      t2_q <= TW'(ct_q) + (TW'(c0) <<< (F - 1));
      a1_q <= ACC'(m30_q) + (ACC'(c20) <<< F);
      b1_q <= ACC'(m21_q) + (ACC'(c11) <<< F);
    end
  end

  // first Horner pass: a1 * psc and b1 * psc
  bpc_pkg::mul_en_t      en_m1, en_m2;
  logic signed [ACC-1:0] ma1, mb1, ma2, mb2;

  assign en_m1 = '{pp: adv[ST_M1], part: adv[ST_M1+1], sum: adv[ST_M1+2], rnd: adv[ST_M1+3]};
  assign en_m2 = '{pp: adv[ST_M2], part: adv[ST_M2+1], sum: adv[ST_M2+2], rnd: adv[ST_M2+3]};

  bpc_mul_round #(.BW(PW), .SH(F)) u_mul_a1 (
    .clk_i (clk_i),
    .en_i  (en_m1),
    .a_i   (a1_q),
    .b_i   (psc_q[ST_ADD1]),
    .q_o   (ma1)
  );

  bpc_mul_round #(.BW(PW), .SH(F)) u_mul_b1 (
    .clk_i (clk_i),
    .en_i  (en_m1),
    .a_i   (b1_q),
    .b_i   (psc_q[ST_ADD1]),
    .q_o   (mb1)
  );

  // temperature: round to 1/256 degree, clamp, then ride along to the output
  logic signed [TW-1:0]  t_corr, t_adj, t_sh;
  logic signed [TRW-1:0] tr_q;
  logic signed [63:0]    tr64;
  logic signed [31:0]    tmp_q [ST_M1+1:ST_OUT];
  logic signed [31:0]    tmp_clamp;

  always_comb begin
    t_corr = TW'(t2_q[TW-1]);
    t_adj  = t2_q + T_HALF - t_corr;
    t_sh   = t_adj >>> (F - 8);
    tr64   = 64'(tr_q);
    if (tr64 > T_MAX) begin
      tmp_clamp = 32'(T_MAX);
    end else if (tr64 < T_MIN) begin
      tmp_clamp = 32'(T_MIN);
    end else begin
      tmp_clamp = 32'(tr64);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_M1]) begin
      tr_q <= t_sh[TRW-1:0];
    end
    if (adv[ST_M1+1]) begin
      tmp_q[ST_M1+1] <= tmp_clamp;
    end
    for (int k = ST_M1 + 2; k <= ST_OUT; k++) begin
      if (adv[k]) begin
        tmp_q[k] <= tmp_q[k-1];
      end
    end
  end

  logic signed [ACC-1:0] a2_q, b2_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_ADD2]) begin
      a2_q <= ma1 + (ACC'(c10) <<< F);
      b2_q <= mb1 + (ACC'(c01) <<< F);
    end
  end

  // second pass: a2 * psc and b2 * tsc
  bpc_mul_round #(.BW(PW), .SH(F)) u_mul_a2 (
    .clk_i (clk_i),
    .en_i  (en_m2),
    .a_i   (a2_q),
    .b_i   (psc_q[ST_ADD2]),
    .q_o   (ma2)
  );

  bpc_mul_round #(.BW(PW), .SH(F)) u_mul_b2 (
    .clk_i (clk_i),
    .en_i  (en_m2),
    .a_i   (b2_q),
    .b_i   (tsc_q[ST_ADD2]),
    .q_o   (mb2)
  );

  logic signed [ACC-1:0] a3_q, b3_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_ADD3]) begin
      a3_q <= ma2 + (ACC'(c00) <<< F);
      b3_q <= mb2;
    end
  end

  // final sum saturates to the accumulator range
  logic signed [ACC1-1:0] p_sum;
  logic signed [ACC-1:0]  p_sat;
  logic signed [ACC-1:0]  p_q;

  always_comb begin
    p_sum = ACC1'(a3_q) + ACC1'(b3_q);
    if (p_sum[ACC] != p_sum[ACC-1]) begin
      p_sat = p_sum[ACC] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
    end else begin
      p_sat = p_sum[ACC-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SUM]) begin
      p_q <= p_sat;
    end
  end

  logic signed [ACC1-1:0] p_corr, p_adj, p_sh;
  logic signed [PRW-1:0]  pr_q;
  logic signed [63:0]     pr64;
  logic signed [39:0]     pres_clamp, pres_q;

  always_comb begin
    p_corr = ACC1'(p_q[ACC-1]);
    p_adj  = ACC1'(p_q) + P_HALF - p_corr;
    p_sh   = p_adj >>> (F - 6);
    pr64   = 64'(pr_q);
    if (pr64 > P_MAX) begin
      pres_clamp = 40'(P_MAX);
    end else if (pr64 < P_MIN) begin
      pres_clamp = 40'(P_MIN);
    end else begin
      pres_clamp = 40'(pr64);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_RND]) begin
      pr_q <= p_sh[PRW-1:0];
    end
    if (adv[ST_OUT]) begin
      pres_q <= pres_clamp;
    end
  end

  assign m_axis_tdata = {pres_q, tmp_q[ST_OUT]};

  // an empty pipeline never holds off a request
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

  // an accepted request occupies the first stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[ST_SCALE])
    else $error("accepted request lost at the first stage");

  // a blocked first stage keeps its item and its scaled temperature
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_SCALE] && !adv[ST_MULC]) |=> (v_q[ST_SCALE] && $stable(tsc_q[ST_SCALE])))
    else $error("first stage changed while blocked");

  // an empty output register always loads
  a_out_empty_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[ST_OUT] |-> adv[ST_OUT])
    else $error("empty output stage not loading");

  // temperature oversampling code write lands in its register
  a_osr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == bpc_pkg::REG_TEMP_OSR))
      |=> (temp_osr_q == $past(cfg_data_i[2:0])))
    else $error("temperature oversampling write not taken");

endmodule
